### design/snw_pkg.sv
// Shared types, constants and helpers for the stop-and-wait packet endpoint.
`default_nettype none
package snw_pkg;

	localparam int PAYLOAD_MAX_DEF = 1024;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
	localparam logic [15:0] TICK_SAT = 16'hFFFF;
	localparam logic [7:0] PKT_DATA = 8'd1;
	localparam logic [7:0] PKT_ACK = 8'd2;
	// ack header: version 1 + type 2
	localparam logic [15:0] ACK_HDR_SUM = 16'd3;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_HDR  = 2'd0,
		OP_BYTE = 2'd1,
		OP_TICK = 2'd2,
		OP_SEND = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		EV_OTHER    = 3'd0,
		EV_CHK_ERR  = 3'd1,
		EV_SEND_ACK = 3'd2,
		EV_ACK_OK   = 3'd3,
		EV_STALE    = 3'd4,
		EV_RETX     = 3'd5,
		EV_TX_NEW   = 3'd6
	} event_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0
	} reg_idx_t;

	// sum of the two 16-bit halves, wrapping
	function automatic logic [15:0] halves(input logic [31:0] v);
		halves = v[15:0] + v[31:16];
	endfunction

endpackage
`default_nettype wire

### design/snw_item_if.sv
// Input channel: received header, payload byte, tick and send requests.
`default_nettype none
interface snw_item_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [7:0] version;
	logic [7:0] pkt_type;
	logic [31:0] seq_number;
	logic [31:0] ack_number;
	logic [10:0] payload_len;
	logic [7:0] flag_bits;
	logic [15:0] check_value;
	logic signed [7:0] payload_byte;

	modport source (
		output valid, opcode, version, pkt_type, seq_number, ack_number,
		payload_len, flag_bits, check_value, payload_byte,
		input ready
	);
	modport sink (
		input valid, opcode, version, pkt_type, seq_number, ack_number,
		payload_len, flag_bits, check_value, payload_byte,
		output ready
	);
endinterface
`default_nettype wire

### design/snw_result_if.sv
// Result channel: event with outgoing numbers and link status.
`default_nettype none
interface snw_result_if;
	logic valid;
	logic ready;
	logic [2:0] event_res;
	logic [31:0] out_seq;
	logic [31:0] out_ack;
	logic [15:0] out_checksum;
	logic [31:0] expected_next;
	logic waiting_ack;

	modport source (
		output valid, event_res, out_seq, out_ack, out_checksum, expected_next,
		waiting_ack,
		input ready
	);
	modport sink (
		input valid, event_res, out_seq, out_ack, out_checksum, expected_next,
		waiting_ack,
		output ready
	);
endinterface
`default_nettype wire

### design/stop_and_wait_packet_endpoint.sv
// Top level of the stop-and-wait packet endpoint.
//
//  channel  | dir | handshake     | beat
//  ---------+-----+---------------+------------------------------------------
//  item     | in  | valid/ready   | header, payload byte, tick or send request
//  result   | out | valid/ready   | event, outgoing numbers, link status
//  apb      | in  | psel/penable  | timeout register write/read
//
// One item per cycle unless the input stage stalls: an item is registered,
// evaluated by the checksum and sequence logic in the next cycle and, if it
// yields an event, loaded into the result register. The input stage stalls
// only when an item with an event meets a full, unread result register.
// Reset clears the counters and link state; the timeout resets to 10000 ticks.
`default_nettype none
module stop_and_wait_packet_endpoint #(
	parameter int PAYLOAD_MAX = snw_pkg::PAYLOAD_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	snw_item_if.sink                             item,
	snw_result_if.source                         result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [snw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [snw_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [snw_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import snw_pkg::*;

	localparam int LEFT_W = $clog2(PAYLOAD_MAX + 1);

	logic [15:0] timeout_ticks;

	snw_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	// input stage
	logic        valid_s1;
	opcode_t     op_s1;
	logic [7:0]  version_s1;
	logic [7:0]  type_s1;
	logic [31:0] seq_s1;
	logic [31:0] ack_s1;
	logic [10:0] len_s1;
	logic [7:0]  flags_s1;
	logic [15:0] check_s1;
	logic [7:0]  byte_s1;

	// endpoint state
	logic [15:0]       sum_q;
	logic [LEFT_W-1:0] left_q;
	logic [7:0]        type_q;
	logic [31:0]       seq_q;
	logic [31:0]       ack_q;
	logic [15:0]       check_q;
	logic [31:0]       expect_q;
	logic [31:0]       next_q;
	logic [31:0]       outst_q;
	logic              awaiting_q;
	logic [15:0]       tick_q;

	logic [15:0]       sum_d;
	logic [LEFT_W-1:0] left_d;
	logic [31:0]       expect_d;
	logic [31:0]       next_d;
	logic [31:0]       outst_d;
	logic              awaiting_d;
	logic [15:0]       tick_d;
	logic              hdr_load;

	// values the packet is judged on
	logic        judge_go;
	logic [15:0] sum_j;
	logic [7:0]  type_j;
	logic [31:0] seq_j;
	logic [31:0] ack_j;
	logic [15:0] check_j;
	logic [15:0] tick_inc;

	logic        res_hit;
	event_t      ev;
	logic [31:0] res_seq;
	logic [31:0] res_ack;
	logic [15:0] res_chk;
	logic        adv;

	// result register
	logic        out_valid_q;
	event_t      ev_q;
	logic [31:0] out_seq_q;
	logic [31:0] out_ack_q;
	logic [15:0] out_chk_q;
	logic [31:0] out_exp_q;
	logic        out_wait_q;

	assign adv = valid_s1 && (!res_hit || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_HDR;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
			if (item.valid) begin
				op_s1 <= opcode_t'(item.opcode);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			version_s1 <= item.version;
			type_s1    <= item.pkt_type;
			seq_s1     <= item.seq_number;
			ack_s1     <= item.ack_number;
			len_s1     <= item.payload_len;
			flags_s1   <= item.flag_bits;
			check_s1   <= item.check_value;
			byte_s1    <= item.payload_byte;
		end
	end

	assign tick_inc = (tick_q < TICK_SAT) ? tick_q + 16'd1 : tick_q;

	always_comb begin
		sum_d      = sum_q;
		left_d     = left_q;
		expect_d   = expect_q;
		next_d     = next_q;
		outst_d    = outst_q;
		awaiting_d = awaiting_q;
		tick_d     = tick_q;
		hdr_load   = 1'b0;
		judge_go   = 1'b0;
		sum_j      = sum_q;
		type_j     = type_q;
		seq_j      = seq_q;
		ack_j      = ack_q;
		check_j    = check_q;
		res_hit    = 1'b0;
		ev         = EV_OTHER;
		res_seq    = '0;
		res_ack    = '0;
		res_chk    = '0;

		unique case (op_s1)
			OP_HDR: begin
				hdr_load = 1'b1;
				sum_d = 16'({8'd0, version_s1}) + 16'({8'd0, type_s1}) + halves(seq_s1)
					+ halves(ack_s1) + 16'({5'd0, len_s1}) + 16'({8'd0, flags_s1});
				if (32'({21'd0, len_s1}) > 32'(PAYLOAD_MAX)) begin
					left_d = LEFT_W'(PAYLOAD_MAX);
				end else begin
					left_d = LEFT_W'(len_s1);
				end
				judge_go = (len_s1 == 11'd0);
				sum_j    = sum_d;
				type_j   = type_s1;
				seq_j    = seq_s1;
				ack_j    = ack_s1;
				check_j  = check_s1;
			end
			OP_BYTE: begin
				if (left_q != '0) begin
					sum_d    = sum_q + {{8{byte_s1[7]}}, byte_s1};
					left_d   = left_q - LEFT_W'(1);
					judge_go = (left_d == '0);
					sum_j    = sum_d;
				end
			end
			OP_TICK: begin
				if (awaiting_q) begin
					if (tick_inc >= timeout_ticks) begin
						tick_d  = '0;
						res_hit = 1'b1;
						ev      = EV_RETX;
						res_seq = outst_q;
					end else begin
						tick_d = tick_inc;
					end
				end
			end
			OP_SEND: begin
				if (!awaiting_q) begin
					outst_d    = next_q;
					next_d     = next_q + 32'd1;
					awaiting_d = 1'b1;
					tick_d     = '0;
					res_hit    = 1'b1;
					ev         = EV_TX_NEW;
					res_seq    = next_q;
				end
			end
		endcase

		if (judge_go) begin
			res_hit = 1'b1;
			if (~sum_j != check_j) begin
				ev = EV_CHK_ERR;
			end else begin
				expect_d = seq_j + 32'd1;
				if (type_j == PKT_DATA) begin
					ev      = EV_SEND_ACK;
					res_ack = seq_j;
					res_chk = ~(ACK_HDR_SUM + halves(seq_j));
				end else if (type_j == PKT_ACK) begin
					res_ack = ack_j;
					if (awaiting_q && ack_j == outst_q) begin
						awaiting_d = 1'b0;
						tick_d     = '0;
						ev         = EV_ACK_OK;
					end else begin
						ev = EV_STALE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			expect_q   <= '0;
			next_q     <= '0;
			outst_q    <= '0;
			awaiting_q <= 1'b0;
			tick_q     <= '0;
		end else if (adv) begin
			left_q     <= left_d;
			expect_q   <= expect_d;
			next_q     <= next_d;
			outst_q    <= outst_d;
			awaiting_q <= awaiting_d;
			tick_q     <= tick_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_q <= sum_d;
		end
		if (adv && hdr_load) begin
			type_q  <= type_s1;
			seq_q   <= seq_s1;
			ack_q   <= ack_s1;
			check_q <= check_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_hit) begin
			ev_q       <= ev;
			out_seq_q  <= res_seq;
			out_ack_q  <= res_ack;
			out_chk_q  <= res_chk;
			out_exp_q  <= expect_d;
			out_wait_q <= awaiting_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.event_res     = 3'(ev_q);
	assign result.out_seq       = out_seq_q;
	assign result.out_ack       = out_ack_q;
	assign result.out_checksum  = out_chk_q;
	assign result.expected_next = out_exp_q;
	assign result.waiting_ack   = out_wait_q;

	a_idle_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!awaiting_q |-> tick_q == 16'd0)
		else $error("tick counter running with nothing outstanding");

	a_seq_follows: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> next_q == 32'(outst_q + 32'd1))
		else $error("next sequence not one past outstanding");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(left_q) <= 32'(PAYLOAD_MAX))
		else $error("payload byte count above limit");

	a_tx_waits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ev_q == EV_TX_NEW |-> out_wait_q)
		else $error("new transmission reported without waiting for ack");
endmodule
`default_nettype wire

### design/snw_apb_regs.sv
// APB register block holding the retransmit timeout.
`default_nettype none
module snw_apb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [snw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [snw_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [snw_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output logic      [15:0]                     timeout_ticks
);
	import snw_pkg::*;

	logic [15:0] timeout_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign timeout_ticks = timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en && idx == REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:     prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

### dv/snw_tb_pkg.sv
`timescale 1ns / 100ps
// Item and event types plus a cycle-free mirror of the endpoint that predicts and checks events.
package snw_tb_pkg;
	import snw_pkg::*;

	typedef struct {
		opcode_t           op;
		logic [7:0]        version;
		logic [7:0]        pkt_type;
		logic [31:0]       seq;
		logic [31:0]       ack;
		logic [10:0]       len;
		logic [7:0]        flags;
		logic [15:0]       check;
		logic signed [7:0] data;
	} item_t;

	typedef struct {
		event_t      ev;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] csum;
		logic [31:0] rx_next;
		logic        waiting;
	} link_event_t;

	// wrapping sum over the header fields, 32-bit numbers split in halves
	function automatic logic [15:0] header_sum(input item_t h);
		logic [15:0] s;
		s = 16'(h.version) + 16'(h.pkt_type) + h.seq[15:0] + h.seq[31:16] + h.ack[15:0]
			+ h.ack[31:16] + 16'(h.len) + 16'(h.flags);
		return s;
	endfunction

	function automatic logic [15:0] widen_byte(input logic signed [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

	class endpoint_mirror;
		logic [15:0] timeout;
		logic [15:0] run_sum;
		logic [15:0] ticks;
		logic [10:0] left;
		logic [7:0]  hdr_type;
		logic [31:0] hdr_seq;
		logic [31:0] hdr_ack;
		logic [15:0] hdr_check;
		logic [31:0] rx_expect;
		logic [31:0] tx_next;
		logic [31:0] tx_outstanding;
		logic        awaiting_ack;
		link_event_t owed_events[$];
		int unsigned errors;
		int unsigned useful;
		int unsigned matched[8];

		function new();
			timeout = TIMEOUT_RESET;
			run_sum = '0;
			ticks = '0;
			left = '0;
			hdr_type = '0;
			hdr_seq = '0;
			hdr_ack = '0;
			hdr_check = '0;
			rx_expect = '0;
			tx_next = '0;
			tx_outstanding = '0;
			awaiting_ack = 1'b0;
			errors = 0;
			useful = 0;
			foreach (matched[i])
				matched[i] = 0;
		endfunction

		function void set_timeout(input logic [15:0] value);
			timeout = value;
		endfunction

		function void owe(input event_t ev, input logic [31:0] seq, input logic [31:0] ack,
				input logic [15:0] csum);
			link_event_t e;
			e.ev = ev;
			e.seq = seq;
			e.ack = ack;
			e.csum = csum;
			e.rx_next = rx_expect;
			e.waiting = awaiting_ack;
			owed_events.push_back(e);
		endfunction

		function void close_packet();
			logic [15:0] s;
			if (~run_sum != hdr_check) begin
				owe(EV_CHK_ERR, '0, '0, '0);
			end else begin
				rx_expect = hdr_seq + 32'd1;
				if (hdr_type == PKT_DATA) begin
					s = ACK_HDR_SUM + hdr_seq[15:0] + hdr_seq[31:16];
					owe(EV_SEND_ACK, '0, hdr_seq, ~s);
				end else if (hdr_type == PKT_ACK) begin
					if (awaiting_ack && hdr_ack == tx_outstanding) begin
						awaiting_ack = 1'b0;
						ticks = '0;
						owe(EV_ACK_OK, '0, hdr_ack, '0);
					end else
						owe(EV_STALE, '0, hdr_ack, '0);
				end else
					owe(EV_OTHER, '0, '0, '0);
			end
		endfunction

		function void take_item(input item_t it);
			case (it.op)
				OP_HDR: begin
					hdr_type = it.pkt_type;
					hdr_seq = it.seq;
					hdr_ack = it.ack;
					hdr_check = it.check;
					run_sum = header_sum(it);
					left = (it.len > PAYLOAD_MAX_DEF) ? 11'(PAYLOAD_MAX_DEF) : it.len;
					useful++;
					if (left == 0)
						close_packet();
				end
				OP_BYTE: begin
					if (left != 0) begin
						run_sum += widen_byte(it.data);
						left--;
						useful++;
						if (left == 0)
							close_packet();
					end
				end
				OP_TICK: begin
					if (awaiting_ack) begin
						useful++;
						if (ticks != TICK_SAT)
							ticks++;
						if (ticks >= timeout) begin
							ticks = '0;
							owe(EV_RETX, tx_outstanding, '0, '0);
						end
					end
				end
				default: begin
					if (!awaiting_ack) begin
						useful++;
						tx_outstanding = tx_next;
						tx_next++;
						awaiting_ack = 1'b1;
						ticks = '0;
						owe(EV_TX_NEW, tx_outstanding, '0, '0);
					end
				end
			endcase
		endfunction

		function void report(input string what, input logic [31:0] want, input logic [31:0] got);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			errors++;
		endfunction

		function void match_event(input link_event_t got);
			link_event_t want;
			if (owed_events.size() == 0) begin
				$display("%0t: event %0d with nothing outstanding", $time, got.ev);
				errors++;
			end else begin
				want = owed_events.pop_front();
				matched[want.ev]++;
				if (got.ev !== want.ev)
					report("event_res", want.ev, got.ev);
				if (got.seq !== want.seq)
					report("out_seq", want.seq, got.seq);
				if (got.ack !== want.ack)
					report("out_ack", want.ack, got.ack);
				if (got.csum !== want.csum)
					report("out_checksum", want.csum, got.csum);
				if (got.rx_next !== want.rx_next)
					report("expected_next", want.rx_next, got.rx_next);
				if (got.waiting !== want.waiting)
					report("waiting_ack", want.waiting, got.waiting);
			end
		endfunction
	endclass

endpackage

### dv/tb_stop_and_wait_packet_endpoint.sv
`timescale 1ns / 100ps
// Top-level testbench: drives packets, ticks, sends and timeout writes, checks every event.
module tb_stop_and_wait_packet_endpoint;
	import snw_pkg::*;
	import snw_tb_pkg::*;

	localparam int WHOLE = 4096;
	localparam int PHASE_ITEMS = 72;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [15:0] TIMEOUTS [6] = '{16'd4, 16'd65535, 16'd2, 16'd1, 16'd0, 16'd25};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	bit calm;
	bit hold_request;
	int unsigned holds_done;
	int unsigned items_accepted;
	int unsigned quiet;

	endpoint_mirror mirror = new();

	snw_item_if item_bus();
	snw_result_if event_bus();

	stop_and_wait_packet_endpoint dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(event_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic item_t noise_item(input opcode_t op);
		item_t it;
		it.op = op;
		it.version = 8'($urandom);
		it.pkt_type = 8'($urandom);
		it.seq = $urandom;
		it.ack = $urandom;
		it.len = 11'($urandom);
		it.flags = 8'($urandom);
		it.check = 16'($urandom);
		it.data = 8'($urandom);
		return it;
	endfunction

	function automatic item_t make_header(input logic [7:0] ptype, input logic [31:0] seq,
			input logic [31:0] ack, input logic [10:0] len);
		item_t h;
		h = noise_item(OP_HDR);
		h.pkt_type = ptype;
		h.seq = seq;
		h.ack = ack;
		h.len = len;
		return h;
	endfunction

	function automatic logic [10:0] body_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return 11'($urandom_range(0, 4));
		if (r < 95)
			return 11'($urandom_range(5, 24));
		return 11'($urandom_range(25, 80));
	endfunction

	// called and returns at a falling edge
	task automatic push_item(input item_t it);
		while (!calm && $urandom_range(99) < 12) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.opcode <= it.op;
		item_bus.version <= it.version;
		item_bus.pkt_type <= it.pkt_type;
		item_bus.seq_number <= it.seq;
		item_bus.ack_number <= it.ack;
		item_bus.payload_len <= it.len;
		item_bus.flag_bits <= it.flags;
		item_bus.check_value <= it.check;
		item_bus.payload_byte <= it.data;
		do @(posedge clk); while (!item_bus.ready);
		@(negedge clk);
	endtask

	task automatic deliver_packet(input item_t hdr, input bit corrupt, input int cut,
			input bit extreme_bytes);
		item_t body[$];
		item_t b;
		logic [15:0] s;
		int n;
		hdr.op = OP_HDR;
		s = header_sum(hdr);
		n = (hdr.len > PAYLOAD_MAX_DEF) ? PAYLOAD_MAX_DEF : hdr.len;
		for (int i = 0; i < n; i++) begin
			b = noise_item(OP_BYTE);
			if (extreme_bytes)
				b.data = (i % 2 == 0) ? 8'h80 : 8'h7F;
			s += widen_byte(b.data);
			body.push_back(b);
		end
		hdr.check = ~s;
		if (corrupt)
			hdr.check ^= 16'($urandom_range(1, 65535));
		push_item(hdr);
		for (int i = 0; i < body.size() && i < cut; i++)
			push_item(body[i]);
	endtask

	task automatic settle();
		item_bus.valid <= 1'b0;
		while (mirror.owed_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * REG_TIMEOUT);
		pwdata <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mirror.set_timeout(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_directed();
		item_t h;
		push_item(noise_item(OP_BYTE));
		push_item(noise_item(OP_TICK));
		h = make_header(PKT_DATA, '1, '1, 11'd0);
		h.version = '1;
		h.flags = '1;
		deliver_packet(h, 1'b0, WHOLE, 1'b0);
		h = make_header(PKT_DATA, '0, '0, 11'd2);
		h.version = '0;
		h.flags = '0;
		deliver_packet(h, 1'b0, WHOLE, 1'b1);
		push_item(noise_item(OP_SEND));
		push_item(noise_item(OP_SEND));
		deliver_packet(make_header(PKT_ACK, 32'd1, 32'd0, 11'd0), 1'b0, WHOLE, 1'b0);
		// nothing outstanding, then a wrong number
		deliver_packet(make_header(PKT_ACK, 32'd2, 32'd0, 11'd0), 1'b0, WHOLE, 1'b0);
		push_item(noise_item(OP_SEND));
		deliver_packet(make_header(PKT_ACK, 32'd3, 32'd5, 11'd1), 1'b0, WHOLE, 1'b0);
		deliver_packet(make_header(8'h00, 32'd4, 32'd0, 11'd0), 1'b0, WHOLE, 1'b0);
		deliver_packet(make_header(8'hFF, 32'd5, 32'd0, 11'd0), 1'b0, WHOLE, 1'b0);
		deliver_packet(make_header(PKT_DATA, 32'd6, 32'd0, 11'd1), 1'b1, WHOLE, 1'b0);
		// header arrives mid-payload
		deliver_packet(make_header(PKT_DATA, 32'd7, 32'd0, 11'd3), 1'b0, 1, 1'b0);
		deliver_packet(make_header(PKT_DATA, 32'd8, 32'd0, 11'd0), 1'b0, WHOLE, 1'b0);
		settle();
		write_timeout(16'd1);
		push_item(noise_item(OP_TICK));
		settle();
		write_timeout(16'd0);
		push_item(noise_item(OP_TICK));
		deliver_packet(make_header(PKT_ACK, 32'd9, 32'd1, 11'd0), 1'b0, WHOLE, 1'b0);
	endtask

	task automatic random_phase(input int unsigned quota, input bit jumbo, input bit squeeze);
		int unsigned goal;
		int unsigned pick;
		int unsigned reps;
		item_t h;
		goal = mirror.useful + quota;
		if (jumbo) begin
			h = make_header(PKT_DATA, mirror.rx_expect, $urandom, 11'h7FF);
			deliver_packet(h, 1'b0, WHOLE, 1'b0);
		end
		while (mirror.useful < goal) begin
			if (squeeze && mirror.useful >= goal - quota / 2) begin
				squeeze = 1'b0;
				hold_request = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 30) begin
				h = make_header(PKT_DATA,
					($urandom_range(3) != 0) ? mirror.rx_expect : $urandom, $urandom, body_len());
				deliver_packet(h, 1'b0, WHOLE, 1'b0);
			end else if (pick < 50) begin
				h = make_header(PKT_ACK, mirror.rx_expect,
					(mirror.awaiting_ack && $urandom_range(4) != 0) ? mirror.tx_outstanding
						: $urandom,
					($urandom_range(3) == 0) ? body_len() : 11'd0);
				deliver_packet(h, 1'b0, WHOLE, 1'b0);
			end else if (pick < 60) begin
				push_item(noise_item(OP_SEND));
			end else if (pick < 72) begin
				reps = $urandom_range(1, 4);
				repeat (reps) push_item(noise_item(OP_TICK));
			end else if (pick < 77) begin
				h = make_header($urandom_range(1) ? 8'($urandom_range(3, 255)) : 8'h00,
					$urandom, $urandom, body_len());
				deliver_packet(h, 1'b0, WHOLE, 1'b0);
			end else if (pick < 82) begin
				h = make_header(8'($urandom_range(0, 3)), $urandom, $urandom, body_len());
				deliver_packet(h, 1'b1, WHOLE, 1'b0);
			end else if (pick < 87) begin
				reps = $urandom_range(2, 10);
				h = make_header(PKT_DATA, mirror.rx_expect, $urandom, 11'(reps));
				deliver_packet(h, 1'b0, $urandom_range(0, reps - 1), 1'b0);
			end else if (pick < 91) begin
				push_item(noise_item(OP_BYTE));
			end else
				push_item(noise_item(opcode_t'($urandom_range(3))));
		end
	endtask

	initial begin
		event_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				event_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				holds_done++;
			end else
				event_bus.ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	always @(posedge clk) begin
		item_t took;
		link_event_t got;
		if (arst_n) begin
			if (event_bus.valid && event_bus.ready) begin
				got.ev = event_t'(event_bus.event_res);
				got.seq = event_bus.out_seq;
				got.ack = event_bus.out_ack;
				got.csum = event_bus.out_checksum;
				got.rx_next = event_bus.expected_next;
				got.waiting = event_bus.waiting_ack;
				mirror.match_event(got);
			end
			if (item_bus.valid && item_bus.ready) begin
				took.op = opcode_t'(item_bus.opcode);
				took.version = item_bus.version;
				took.pkt_type = item_bus.pkt_type;
				took.seq = item_bus.seq_number;
				took.ack = item_bus.ack_number;
				took.len = item_bus.payload_len;
				took.flags = item_bus.flag_bits;
				took.check = item_bus.check_value;
				took.data = item_bus.payload_byte;
				mirror.take_item(took);
				items_accepted++;
			end
			if ((event_bus.valid && event_bus.ready) || (item_bus.valid && item_bus.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no beat on either channel for %0d cycles", $time, QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.opcode = OP_HDR;
		item_bus.version = '0;
		item_bus.pkt_type = '0;
		item_bus.seq_number = '0;
		item_bus.ack_number = '0;
		item_bus.payload_len = '0;
		item_bus.flag_bits = '0;
		item_bus.check_value = '0;
		item_bus.payload_byte = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		run_directed();
		foreach (TIMEOUTS[i]) begin
			settle();
			write_timeout(TIMEOUTS[i]);
			calm = (i == 1);
			random_phase(PHASE_ITEMS, i == 2, i == 3);
		end
		calm = 1'b0;
		settle();

		$display("covered %0d beats in (%0d acted on), %0d receiver hold-offs, %0d timeout values",
			items_accepted, mirror.useful, holds_done, $size(TIMEOUTS) + 3);
		$display("events: other %0d, bad sum %0d, ack out %0d, ack ok %0d, stale %0d, %s %0d/%0d",
			mirror.matched[EV_OTHER], mirror.matched[EV_CHK_ERR], mirror.matched[EV_SEND_ACK],
			mirror.matched[EV_ACK_OK], mirror.matched[EV_STALE], "resend/new",
			mirror.matched[EV_RETX], mirror.matched[EV_TX_NEW]);
		if (mirror.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
